// File: rtl/lvp_pkg.sv
// Shared types and constants for the longest valid parenthesis run block.
`timescale 1ns / 1ps

package lvp_pkg;

  // Longest string that is tracked before the overflow flag freezes the result.
  localparam int unsigned MaxLenDef = 4096;

  // Width of the reported run length.
  localparam int unsigned LenW = 13;

  // Byte code of an opening bracket; every other byte closes.
  localparam logic [7:0] OpenCode = 8'd40;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [LenW-1:0] best_length;
    logic            string_end;
    logic            length_overflow;
  } out_item_t;

endpackage

// File: rtl/lvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lvp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lvp_core.sv
// Position stack, run tracking and per-string state; one character per cycle of step_i.
`timescale 1ns / 1ps

module lvp_core import lvp_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  localparam int unsigned Depth = MaxLen + 1;
  localparam int unsigned PosW  = $clog2(MaxLen + 1);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned AddrW = $clog2(Depth);

  // Stack entries hold position plus one; the sentinel is zero.
  // top_q and below_q hold the two upper entries, bottom_q entry zero,
  // and stack_rd always presents the entry under below_q, from the RAM read port or bottom_q.
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PosW-1:0]  top_q, top_d;
  logic [PosW-1:0]  below_q, below_d;
  logic [PosW-1:0]  bottom_q, bottom_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  best_q, best_d;
  logic             ovf_q, ovf_d;
  logic             rd_zero_q, rd_zero_d;

  logic [PosW-1:0]  pos_next;
  logic [PosW-1:0]  run_len;
  logic             ovf_now;
  logic [PosW-1:0]  stack_rd;
  logic [PosW-1:0]  ram_rdata;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;

  lvp_ram #(
    .Width (PosW),
    .Depth (Depth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (pos_next),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry zero lives in a register so the sentinel needs no RAM write.
  assign stack_rd = rd_zero_q ? bottom_q : ram_rdata;
  assign pos_next = pos_q + PosW'(1);
  assign run_len  = pos_next - below_q;
  assign ovf_now  = ovf_q || (pos_q >= PosW'(MaxLen));

  always_comb begin
    cnt_d     = cnt_q;
    top_d     = top_q;
    below_d   = below_q;
    bottom_d  = bottom_q;
    pos_d     = pos_q;
    best_d    = best_q;
    ovf_d     = ovf_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AddrW-1:0];

    if (step_i) begin
      ovf_d = ovf_now;
      if (!ovf_now) begin
        pos_d = pos_next;
        if (item_i.char_code == OpenCode) begin
          if (cnt_q < CntW'(Depth)) begin
            ram_we  = 1'b1;
            below_d = top_q;
            top_d   = pos_next;
            cnt_d   = cnt_q + CntW'(1);
          end
        end else if (cnt_q == CntW'(1)) begin
          // Popped the last entry: the current position becomes the new base.
          top_d    = pos_next;
          bottom_d = pos_next;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          top_d   = below_q;
          below_d = stack_rd;
          if (run_len > best_q) begin
            best_d = run_len;
          end
        end
      end
    end

    result_o.best_length     = LenW'(best_d);
    result_o.string_end      = item_i.last_char;
    result_o.length_overflow = ovf_d;

    // Clear for the next string once the result is formed.
    if (step_i && item_i.last_char) begin
      cnt_d    = CntW'(1);
      top_d    = '0;
      below_d  = '0;
      bottom_d = '0;
      pos_d    = '0;
      best_d   = '0;
      ovf_d    = 1'b0;
    end

    ram_raddr = AddrW'(cnt_d - CntW'(3));
    rd_zero_d = (cnt_d == CntW'(3));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= CntW'(1);
      top_q     <= '0;
      below_q   <= '0;
      bottom_q  <= '0;
      pos_q     <= '0;
      best_q    <= '0;
      ovf_q     <= 1'b0;
      rd_zero_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      top_q     <= top_d;
      below_q   <= below_d;
      bottom_q  <= bottom_d;
      pos_q     <= pos_d;
      best_q    <= best_d;
      ovf_q     <= ovf_d;
      rd_zero_q <= rd_zero_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CntW'(Depth)))
    else $error("stack count out of range");

  a_string_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.last_char) |=> (cnt_q == CntW'(1)) && (pos_q == '0) && !ovf_q)
    else $error("state not cleared after last character");

  a_ovf_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (pos_q == PosW'(MaxLen)))
    else $error("overflow without full position count");

  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= pos_q)
    else $error("best run longer than characters seen");

  a_ovf_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && ovf_q && !item_i.last_char) |=> $stable(best_q) && $stable(cnt_q))
    else $error("state moved after overflow");

endmodule

// File: rtl/longest_valid_paren_run_top.sv
// Top level of the longest valid parenthesis run block: item registers and core.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | into      | in_valid_i / in_stall_o | in_item_i: char_code, last_char
//  out     | out of    | out_valid_o/ out_stall_i| best_length, string_end, length_overflow
//
//  One item per cycle sustained while out_stall_i is low; an accepted item passes
//  through the input register and then the state update into the result
//  register, from which downstream takes it.
//  The per-cycle rate is set by the single stack update: the two upper stack
//  entries sit in registers and the third is prefetched from the RAM read port or, for entry zero, bottom_q.
//  Reset clears the stack to the sentinel alone; no clearing pass is needed.
//  A stall on the output holds the result register and then the input
//  register, and backs up to in_stall_o in the same cycle.

module longest_valid_paren_run_top import lvp_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic      step;
  out_item_t result;

  // Advance the held item when the result register is free or draining.
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  lvp_core #(
    .MaxLen (MaxLen)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // Input register: load a new item whenever the stage is not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register: capture on step, drop once taken downstream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
